@@ hw/rtl/cpm_pkg.sv @@
`timescale 1ns / 1ps

package cpm_pkg;

    // fixed field widths of the word ports
    localparam int OP_W       = 1;
    localparam int TASK_IDX_W = 5;
    localparam int DUR_W      = 16;
    localparam int MASK_W     = 26;
    localparam int MAKESPAN_W = 21;

    localparam int NUM_TASKS_DEF     = 26;
    localparam int DURATION_BITS_DEF = 16;

    localparam logic [OP_W-1:0] OP_DEFINE = 1'b0;
    localparam logic [OP_W-1:0] OP_FINISH = 1'b1;

    localparam logic [MAKESPAN_W-1:0] FINISH_MAX = {MAKESPAN_W{1'b1}};

endpackage

@@ hw/rtl/critical_path_makespan.sv @@
`timescale 1ns / 1ps

// Critical path makespan over a task graph. A define word (operation 0) stores one task:
// duration, root flag (empty prerequisite mask) and its prerequisite bits ORed into the
// task's row; a define word with an index at or above NUM_TASKS is dropped. A finish word
// (operation 1) runs NUM_TASKS relaxation passes with one shared compare/max unit that
// visits one (task, prerequisite) pair per cycle, then a max sweep over all finish times,
// emits the makespan (saturated at 2^21-1) and clears all tasks.
// o_stall is high whenever the block is busy; the result register lets define words be
// taken while a makespan still waits on the output.
module critical_path_makespan
    import cpm_pkg::*;
#(
    parameter int NUM_TASKS     = NUM_TASKS_DEF,
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [TASK_IDX_W-1:0] i_task_index,
    input  logic [DUR_W-1:0]      i_duration,
    input  logic [MASK_W-1:0]     i_prereq_mask,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [MAKESPAN_W-1:0] o_makespan
);

    localparam int TW    = $clog2(NUM_TASKS);
    localparam int SUM_W = ((DURATION_BITS > MAKESPAN_W) ? DURATION_BITS : MAKESPAN_W) + 1;
    localparam logic [TW-1:0] LAST_IDX = TW'(NUM_TASKS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEF_WR,
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_WRITE,
        S_REDUCE,
        S_RDRAIN,
        S_RDONE
    } t_state;

    t_state r_state, n_state;

    logic [TW-1:0]            r_i, r_j, r_pass, r_widx;
    logic                     r_sel;
    logic [NUM_TASKS-1:0]     r_def_vld, r_root;
    logic [NUM_TASKS-1:0]     r_reach [2];

    logic [NUM_TASKS-1:0]     rows_mem [NUM_TASKS];
    logic [DURATION_BITS-1:0] dur_mem  [NUM_TASKS];
    logic [MAKESPAN_W-1:0]    fin_mem  [2][NUM_TASKS];

    logic [NUM_TASKS-1:0]     r_rd_row;
    logic [DURATION_BITS-1:0] r_rd_dur;
    logic                     r_rd_vld;
    logic [MAKESPAN_W-1:0]    r_rd_fin;

    logic [NUM_TASKS-1:0]     r_new_mask;
    logic [DURATION_BITS-1:0] r_new_dur;

    logic                     r_hv, r_hit, r_acc_reach;
    logic [MAKESPAN_W-1:0]    r_best;
    logic                     r_out_vld;
    logic [MAKESPAN_W-1:0]    r_makespan;

    logic                     in_acc, is_finish, idx_ok, out_free, scan_hit, reached_i;
    logic [TW-1:0]            rd_addr;
    logic [NUM_TASKS-1:0]     in_mask, row_eff;
    logic [DURATION_BITS-1:0] dur_eff;
    logic [SUM_W-1:0]         sum;
    logic [MAKESPAN_W-1:0]    sat_fin;

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_vld;
    assign o_makespan = r_makespan;

    assign in_acc    = i_valid && (r_state == S_IDLE);
    assign is_finish = (i_operation == OP_FINISH);
    assign idx_ok    = (32'(i_task_index) < 32'(NUM_TASKS));
    assign out_free  = !r_out_vld || !i_stall;
    assign in_mask   = NUM_TASKS'(i_prereq_mask);

    // one read port: the word's index while idle, the current task otherwise
    assign rd_addr = (r_state == S_IDLE) ? TW'(i_task_index) : r_i;
    assign row_eff = r_rd_vld ? r_rd_row : '0;
    assign dur_eff = r_rd_vld ? r_rd_dur : '0;

    // drop self edges; a prerequisite counts only once reached in the previous pass
    assign scan_hit  = row_eff[r_j] && (r_j != r_i) && r_reach[r_sel][r_j];
    assign reached_i = (r_root[r_i] && r_def_vld[r_i]) || r_acc_reach;
    assign sum       = SUM_W'(r_best) + SUM_W'(dur_eff);
    assign sat_fin   = (sum > SUM_W'(FINISH_MAX)) ? FINISH_MAX : sum[MAKESPAN_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (is_finish) begin
                        n_state = S_LOAD;
                    end else if (idx_ok) begin
                        n_state = S_DEF_WR;
                    end
                end
            end
            S_DEF_WR: n_state = S_IDLE;
            S_LOAD:   n_state = S_SCAN;
            S_SCAN: begin
                if (r_j == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:  n_state = S_WRITE;
            S_WRITE: begin
                if ((r_i == LAST_IDX) && (r_pass == LAST_IDX)) begin
                    n_state = S_REDUCE;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_REDUCE: begin
                if (r_j == LAST_IDX) begin
                    n_state = S_RDRAIN;
                end
            end
            S_RDRAIN: n_state = S_RDONE;
            S_RDONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_pass      <= '0;
            r_sel       <= 1'b0;
            r_def_vld   <= '0;
            r_reach[0]  <= '0;
            r_reach[1]  <= '0;
            r_hv        <= 1'b0;
            r_acc_reach <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hv    <= (r_state == S_SCAN) || (r_state == S_REDUCE);
            if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end
            if (r_hv && r_hit) begin
                r_acc_reach <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && is_finish) begin
                        r_i         <= '0;
                        r_j         <= '0;
                        r_pass      <= '0;
                        r_sel       <= 1'b0;
                        r_reach[0]  <= '0;
                        r_reach[1]  <= '0;
                        r_acc_reach <= 1'b0;
                    end
                end
                S_DEF_WR: r_def_vld[r_widx] <= 1'b1;
                S_LOAD:   r_j <= '0;
                S_SCAN, S_REDUCE: begin
                    r_j <= r_j + 1'b1;
                end
                S_WRITE: begin
                    r_reach[~r_sel][r_i] <= reached_i;
                    r_acc_reach          <= 1'b0;
                    r_j                  <= '0;
                    if (r_i == LAST_IDX) begin
                        // pass done: new bank becomes the old one
                        r_i    <= '0;
                        r_sel  <= ~r_sel;
                        r_pass <= r_pass + 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_RDONE: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_def_vld <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= (r_state == S_REDUCE) ? 1'b1 : scan_hit;
        if (in_acc) begin
            r_new_mask <= in_mask;
            r_new_dur  <= DURATION_BITS'(i_duration);
            r_widx     <= TW'(i_task_index);
        end
        if (r_state == S_DEF_WR) begin
            r_root[r_widx] <= (r_new_mask == '0);
        end
        // shared max unit: relaxation scan and final sweep
        if ((in_acc && is_finish) || (r_state == S_WRITE)) begin
            r_best <= '0;
        end else if (r_hv && r_hit && (r_rd_fin > r_best)) begin
            r_best <= r_rd_fin;
        end
        if ((r_state == S_RDONE) && out_free) begin
            r_makespan <= r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_row <= rows_mem[rd_addr];
        r_rd_dur <= dur_mem[rd_addr];
        r_rd_vld <= r_def_vld[rd_addr];
        if (r_state == S_DEF_WR) begin
            rows_mem[r_widx] <= row_eff | r_new_mask;
            dur_mem[r_widx]  <= r_new_dur;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_fin <= fin_mem[r_sel][r_j];
        if (r_state == S_WRITE) begin
            fin_mem[~r_sel][r_i] <= reached_i ? sat_fin : '0;
        end
    end

    a_hv_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hv |-> $past(r_state == S_SCAN || r_state == S_REDUCE))
        else $error("compare stage loaded outside a scan");

    a_write_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> !r_hv)
        else $error("finish time written before the scan drained");

    a_def_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEF_WR) |-> $past(r_state == S_IDLE))
        else $error("define write not preceded by an accepted word");

    a_result_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RDONE) && out_free)
        |=> (r_out_vld && (r_def_vld == '0) && (r_state == S_IDLE)))
        else $error("makespan issued without clearing the task store");

endmodule

@@ test/tb_critical_path_makespan.sv @@
`timescale 1ns / 1ps

module tb_critical_path_makespan;
    import cpm_pkg::*;

    localparam int NT              = NUM_TASKS_DEF;
    localparam int QUIET_LIMIT     = 100000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int RANDOM_WORDS    = 1125;
    localparam int MIN_RANDOM_SETS = 30;

    typedef logic [MAKESPAN_W-1:0] t_span;

    // Mirrors the task tables and computes the makespan of each finished data set.
    class makespan_board;
        logic [DUR_W-1:0]  dur_tab[NT];
        bit                root_tab[NT];
        logic [MASK_W-1:0] row_tab[NT];
        t_span             span_q[$];
        int                words_seen;
        int                spans_checked;
        int                errors;

        function new();
            clear_tasks();
            words_seen    = 0;
            spans_checked = 0;
            errors        = 0;
        endfunction

        function void clear_tasks();
            for (int i = 0; i < NT; i++) begin
                dur_tab[i]  = '0;
                root_tab[i] = 1'b0;
                row_tab[i]  = '0;
            end
        endfunction

        // NT rounds of relaxation, each round reading only the previous round.
        function t_span longest_finish();
            logic [MAKESPAN_W:0] fin[NT];
            logic [MAKESPAN_W:0] nxt[NT];
            bit                  hit[NT];
            bit                  nhit[NT];
            logic [MAKESPAN_W:0] best;
            logic [MASK_W-1:0]   row;
            bit                  reach;
            t_span               top;
            for (int i = 0; i < NT; i++) begin
                fin[i] = '0;
                hit[i] = 1'b0;
            end
            for (int p = 0; p < NT; p++) begin
                for (int i = 0; i < NT; i++) begin
                    row    = row_tab[i];
                    row[i] = 1'b0;  // drop self edge
                    best   = '0;
                    reach  = root_tab[i];
                    for (int j = 0; j < NT; j++) begin
                        if (row[j] && hit[j]) begin
                            reach = 1'b1;
                            if (fin[j] > best) best = fin[j];
                        end
                    end
                    if (reach) begin
                        best   = best + (MAKESPAN_W + 1)'(dur_tab[i]);
                        nxt[i] = (best > (MAKESPAN_W + 1)'(FINISH_MAX)) ?
                                 (MAKESPAN_W + 1)'(FINISH_MAX) : best;
                    end else begin
                        nxt[i] = '0;
                    end
                    nhit[i] = reach;
                end
                fin = nxt;
                hit = nhit;
            end
            top = '0;
            for (int i = 0; i < NT; i++)
                if (fin[i][MAKESPAN_W-1:0] > top) top = fin[i][MAKESPAN_W-1:0];
            return top;
        endfunction

        function void note_word(logic [OP_W-1:0] op, logic [TASK_IDX_W-1:0] idx,
                                logic [DUR_W-1:0] dur, logic [MASK_W-1:0] mask);
            words_seen++;
            if (op == OP_FINISH) begin
                span_q.push_back(longest_finish());
                clear_tasks();
            end else if (idx < NT) begin
                dur_tab[idx]  = dur;
                root_tab[idx] = (mask == '0);
                row_tab[idx]  = row_tab[idx] | mask;
            end
        endfunction

        function void check_span(t_span got);
            t_span want;
            if (span_q.size() == 0) begin
                $error("o_makespan: no result expected, actual %0d", got);
                errors++;
                return;
            end
            want = span_q.pop_front();
            spans_checked++;
            if (got !== want) begin
                $error("o_makespan: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  o_stall;
    logic [OP_W-1:0]       i_operation   = OP_DEFINE;
    logic [TASK_IDX_W-1:0] i_task_index  = '0;
    logic [DUR_W-1:0]      i_duration    = '0;
    logic [MASK_W-1:0]     i_prereq_mask = '0;
    logic                  o_valid;
    logic                  i_stall       = 1'b0;
    logic [MAKESPAN_W-1:0] o_makespan;

    makespan_board board = new();
    bit calm = 1'b0;
    int quiet_cycles = 0;
    int random_words = 0;
    int random_sets  = 0;

    critical_path_makespan dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_task_index  (i_task_index),
        .i_duration    (i_duration),
        .i_prereq_mask (i_prereq_mask),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_makespan    (o_makespan)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < 20);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                board.note_word(i_operation, i_task_index, i_duration, i_prereq_mask);
            if (o_valid && !i_stall)
                board.check_span(o_makespan);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == QUIET_LIMIT) begin
                $display("** critical_path_makespan: FAILED **");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic logic [DUR_W-1:0] random_duration();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return DUR_W'($urandom_range(0, 15));
            default:    return DUR_W'($urandom);
        endcase
    endfunction

    function automatic logic [MASK_W-1:0] random_mask();
        case ($urandom_range(0, 2))
            0:       return MASK_W'($urandom);
            1:       return MASK_W'($urandom & $urandom & $urandom);
            default: return 26'd1 << $urandom_range(0, NT - 1);
        endcase
    endfunction

    // Prerequisites drawn only from tasks earlier in the order keep the graph acyclic.
    function automatic logic [MASK_W-1:0] earlier_mask(input int order[NT], input int k);
        logic [MASK_W-1:0] m;
        m = '0;
        if (k == 0 || $urandom_range(0, 3) == 0) return m;
        repeat ($urandom_range(1, 3)) m[order[$urandom_range(0, k - 1)]] = 1'b1;
        return m;
    endfunction

    task automatic send_word(input logic [OP_W-1:0] op, input logic [TASK_IDX_W-1:0] idx,
                             input logic [DUR_W-1:0] dur, input logic [MASK_W-1:0] mask);
        if (!calm && $urandom_range(0, 99) < 20) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_task_index  <= idx;
        i_duration    <= dur;
        i_prereq_mask <= mask;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Drop valid and hold until every pending makespan has come out.
    task automatic drain_spans();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.span_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_set(input bit broken);
        int order[NT];
        int n;
        int a;
        int t;
        logic [MASK_W-1:0] m;
        for (int i = 0; i < NT; i++) order[i] = i;
        for (int i = NT - 1; i > 0; i--) begin
            a        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[a];
            order[a] = t;
        end
        n = $urandom_range(14, NT);
        for (int k = 0; k < n; k++) begin
            m = broken ? random_mask() : earlier_mask(order, k);
            send_word(OP_DEFINE, TASK_IDX_W'(order[k]), random_duration(), m);
            random_words++;
        end
        repeat ($urandom_range(0, 16)) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(OP_DEFINE, TASK_IDX_W'($urandom_range(NT, 31)), random_duration(),
                          random_mask());
            end else begin
                a = $urandom_range(0, n - 1);
                m = earlier_mask(order, a);
                if ($urandom_range(0, 3) == 0) m[order[a]] = 1'b1;
                send_word(OP_DEFINE, TASK_IDX_W'(order[a]), random_duration(), m);
                random_words++;
            end
        end
        send_word(OP_FINISH, TASK_IDX_W'($urandom_range(0, 31)), random_duration(),
                  random_mask());
        random_words++;
        random_sets++;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty graph
        send_word(OP_FINISH, 5'd0, 16'd0, 26'd0);

        // full-scale durations, self edges, all-ones mask, ignored indexes
        send_word(OP_DEFINE, 5'd0, 16'hFFFF, 26'd0);
        send_word(OP_DEFINE, 5'd25, 16'hFFFF, 26'h2000001);
        send_word(OP_DEFINE, 5'd1, 16'd0, 26'h3FFFFFF);
        send_word(OP_DEFINE, 5'd31, 16'hFFFF, 26'h3FFFFFF);
        send_word(OP_DEFINE, 5'd26, 16'h1234, 26'd0);
        send_word(OP_DEFINE, 5'd24, 16'hFFFF, 26'h0000002);
        send_word(OP_DEFINE, 5'd0, 16'hFFFF, 26'd0);
        send_word(OP_FINISH, 5'd31, 16'hFFFF, 26'h3FFFFFF);

        drain_spans();

        // cycle fed by a root, unreached task, root turned non-root, deep chain
        send_word(OP_DEFINE, 5'd2, 16'hFFFF, 26'h0000008);
        send_word(OP_DEFINE, 5'd3, 16'd7, 26'h0000004);
        send_word(OP_DEFINE, 5'd4, 16'd100, 26'd0);
        send_word(OP_DEFINE, 5'd2, 16'hFFFF, 26'h0000010);
        send_word(OP_DEFINE, 5'd5, 16'hFFFF, 26'h0000040);
        send_word(OP_DEFINE, 5'd7, 16'd10, 26'd0);
        send_word(OP_DEFINE, 5'd7, 16'd20, 26'h0000100);
        send_word(OP_DEFINE, 5'd10, 16'hFFFF, 26'd0);
        send_word(OP_DEFINE, 5'd11, 16'hFFFF, 26'h0000400);
        send_word(OP_DEFINE, 5'd12, 16'hFFFF, 26'h0000C00);
        send_word(OP_FINISH, 5'd0, 16'd0, 26'd0);

        while (random_words < RANDOM_WORDS || random_sets < MIN_RANDOM_SETS) begin
            calm = (random_sets >= 8 && random_sets < 12);
            random_set($urandom_range(0, 7) == 0);
        end
        calm = 1'b0;

        drain_spans();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words in %0d random data sets; checked %0d makespans.",
                 board.words_seen, random_sets, board.spans_checked);
        $display("Mix: roots, chains, redefinitions, self edges, cycles, ignored indexes.");
        if (board.errors == 0 && board.span_q.size() == 0)
            $display("** critical_path_makespan: PASSED **");
        else
            $display("** critical_path_makespan: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/cpm_pkg.sv
hw/rtl/critical_path_makespan.sv
test/tb_critical_path_makespan.sv
